### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the texture alpha classifier RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define TAC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define TAC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/tac_pkg.sv
// ----------------------------------------------------------------------------
// tac_pkg
// Types, constants and texel classification shared by the classifier modules
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int TAC_LANES   = 16;
    localparam int TAC_PAL     = 8;
    localparam int TAC_OUT_W   = 25;
    localparam int TAC_TALLY_W = 5;

    localparam logic [7:0] TAC_CLEAR_MAX  = 8'd16;
    localparam logic [7:0] TAC_OPAQUE_MIN = 8'd250;
    localparam logic [7:0] TAC_PASS_MIN   = 8'd128;
    localparam logic [7:0] TAC_ALPHA_MAX  = 8'd255;

    typedef enum logic [1:0] {
        FMT_BGRA = 2'd0,
        FMT_DXT1 = 2'd1,
        FMT_DXT3 = 2'd2,
        FMT_DXT5 = 2'd3
    } t_fmt;

    typedef struct packed {
        logic clr;
        logic opq;
        logic pas;
    } t_flags;

    typedef struct packed {
        logic   tot;
        t_flags f;
    } t_lane_out;

    typedef struct packed {
        logic [TAC_TALLY_W-1:0] tot;
        logic [TAC_TALLY_W-1:0] clr;
        logic [TAC_TALLY_W-1:0] opq;
        logic [TAC_TALLY_W-1:0] pas;
    } t_tally;

    // load enables of the three pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    function automatic t_flags tac_classify(input logic [7:0] a);
        t_flags f;
        f.clr = (a <= TAC_CLEAR_MAX);
        f.opq = (a >= TAC_OPAQUE_MIN);
        f.pas = (a >= TAC_PASS_MIN);
        return f;
    endfunction

endpackage

### hw/rtl/tac_palette.sv
// ----------------------------------------------------------------------------
// tac_palette
// Two-stage DXT5 alpha palette build, classified per entry
// ----------------------------------------------------------------------------
module tac_palette import tac_pkg::*; (
    input  logic                   i_clk,
    input  t_pipe_en               i_en,
    input  logic [15:0]            i_endpoints,
    output t_flags [TAC_PAL-1:0]   o_pal
);

    localparam int NUM_N = 6;
    localparam int RECIP_SHIFT = 11;
    localparam logic [8:0] RECIP7 = 9'd292;
    localparam logic [8:0] RECIP5 = 9'd409;
    localparam logic [3:0] DIV7 = 4'd7;
    localparam logic [3:0] DIV5 = 4'd5;

    // floor(x / d) by reciprocal multiply, low by at most one, then corrected
    function automatic logic [7:0] div_const(input logic [10:0] x,
                                             input logic [8:0]  recip,
                                             input logic [3:0]  d);
        logic [19:0] p;
        logic [7:0]  q;
        logic [10:0] r;
        p = 20'(x) * 20'(recip);
        q = 8'(p >> RECIP_SHIFT);
        r = x - 11'(11'(q) * 11'(d));
        if (r >= 11'(d)) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

    logic [7:0]  w_a0;
    logic [7:0]  w_a1;
    logic        w_gt;
    logic [10:0] n_num [NUM_N];
    logic [10:0] r_num [NUM_N];
    logic [7:0]  r_a0;
    logic [7:0]  r_a1;
    logic        r_gt;
    t_flags [TAC_PAL-1:0] n_pal;
    t_flags [TAC_PAL-1:0] r_pal;

    assign w_a0 = i_endpoints[7:0];
    assign w_a1 = i_endpoints[15:8];
    assign w_gt = (w_a0 > w_a1);

    // weighted sums of the two endpoints
    always_comb begin
        for (int i = 0; i < NUM_N; i++) begin
            if (w_gt) begin
                n_num[i] = 11'(w_a0) * 11'(6 - i) + 11'(w_a1) * 11'(1 + i);
            end else if (i < 4) begin
                n_num[i] = 11'(w_a0) * 11'(4 - i) + 11'(w_a1) * 11'(1 + i);
            end else begin
                n_num[i] = '0;
            end
        end
    end

    always_comb begin
        n_pal[0] = tac_classify(r_a0);
        n_pal[1] = tac_classify(r_a1);
        for (int i = 0; i < NUM_N; i++) begin
            if (r_gt) begin
                n_pal[2 + i] = tac_classify(div_const(r_num[i], RECIP7, DIV7));
            end else if (i < 4) begin
                n_pal[2 + i] = tac_classify(div_const(r_num[i], RECIP5, DIV5));
            end else if (i == 4) begin
                n_pal[2 + i] = tac_classify(8'd0);
            end else begin
                n_pal[2 + i] = tac_classify(TAC_ALPHA_MAX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_num <= n_num;
            r_a0  <= w_a0;
            r_a1  <= w_a1;
            r_gt  <= w_gt;
        end
        if (i_en.s2) begin
            r_pal <= n_pal;
        end
    end

    assign o_pal = r_pal;

endmodule

### hw/rtl/tac_lane.sv
// ----------------------------------------------------------------------------
// tac_lane
// Per-texel alpha decode and threshold flags for every texture format
// ----------------------------------------------------------------------------
module tac_lane import tac_pkg::*; (
    input  t_fmt                 i_fmt,
    input  logic [3:0]           i_nibble,
    input  logic [1:0]           i_idx2,
    input  logic [2:0]           i_idx3,
    input  logic [7:0]           i_alpha,
    input  logic                 i_alpha_en,
    input  logic                 i_dxt1_solid,
    input  t_flags [TAC_PAL-1:0] i_pal,
    output t_lane_out            o_lane
);

    localparam logic [1:0] DXT1_CLEAR_IDX = 2'd3;

    always_comb begin
        o_lane = '0;
        unique case (i_fmt)
            FMT_BGRA: begin
                o_lane.tot = i_alpha_en;
                o_lane.f   = i_alpha_en ? tac_classify(i_alpha) : '0;
            end
            FMT_DXT1: begin
                o_lane.tot = 1'b1;
                if (i_dxt1_solid || (i_idx2 != DXT1_CLEAR_IDX)) begin
                    o_lane.f.opq = 1'b1;
                    o_lane.f.pas = 1'b1;
                end else begin
                    o_lane.f.clr = 1'b1;
                end
            end
            FMT_DXT3: begin
                // nibble times 17 is the nibble repeated
                o_lane.tot = 1'b1;
                o_lane.f   = tac_classify({i_nibble, i_nibble});
            end
            FMT_DXT5: begin
                o_lane.tot = 1'b1;
                o_lane.f   = i_pal[i_idx3];
            end
        endcase
    end

endmodule

### hw/rtl/tac_merge.sv
// ----------------------------------------------------------------------------
// tac_merge
// Adder trees that merge the lane flags into registered per-item tallies
// ----------------------------------------------------------------------------
module tac_merge import tac_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  t_lane_out [TAC_LANES-1:0]  i_lanes,
    output t_tally                     o_tally
);

    function automatic logic [TAC_TALLY_W-1:0] pop16(input logic [TAC_LANES-1:0] v);
        logic [TAC_TALLY_W-1:0] s [TAC_LANES];
        for (int i = 0; i < TAC_LANES; i++) begin
            s[i] = TAC_TALLY_W'(v[i]);
        end
        // pairwise tree, results packed toward index zero
        for (int w = TAC_LANES >> 1; w >= 1; w = w >> 1) begin
            for (int i = 0; i < w; i++) begin
                s[i] = s[2 * i] + s[2 * i + 1];
            end
        end
        return s[0];
    endfunction

    logic [TAC_LANES-1:0] w_tot;
    logic [TAC_LANES-1:0] w_clr;
    logic [TAC_LANES-1:0] w_opq;
    logic [TAC_LANES-1:0] w_pas;
    t_tally               n_tally;
    t_tally               r_tally;

    always_comb begin
        for (int i = 0; i < TAC_LANES; i++) begin
            w_tot[i] = i_lanes[i].tot;
            w_clr[i] = i_lanes[i].f.clr;
            w_opq[i] = i_lanes[i].f.opq;
            w_pas[i] = i_lanes[i].f.pas;
        end
        n_tally.tot = pop16(w_tot);
        n_tally.clr = pop16(w_clr);
        n_tally.opq = pop16(w_opq);
        n_tally.pas = pop16(w_pas);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tally <= n_tally;
        end
    end

    assign o_tally = r_tally;

endmodule

### hw/rtl/texture_alpha_classifier_unit.sv
// ----------------------------------------------------------------------------
// texture_alpha_classifier_unit - texel alpha statistics and texture class
// One item per cycle while not stalled; a result is valid once its last item is
// accepted and has passed two more pipeline stages, then the counters and output register.
// Stall only when a last item meets a full output register that is stalled.
// Synchronous reset clears counters, stage valids, output valid and format.
// ----------------------------------------------------------------------------
module texture_alpha_classifier_unit import tac_pkg::*; #(
    parameter int COUNT_WIDTH = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_block_word,
    input  logic [1:0]            i_pixel_count,
    input  logic                  i_last_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_alpha_class,
    output logic [TAC_OUT_W-1:0]  o_total_texels,
    output logic [TAC_OUT_W-1:0]  o_clear_texels,
    output logic [TAC_OUT_W-1:0]  o_opaque_texels,
    output logic [TAC_OUT_W-1:0]  o_passing_texels
);

`include "assert_macros.svh"

    localparam int DXT5_IDX_LSB = 16;
    localparam int DXT1_IDX_LSB = 32;

    typedef enum logic [1:0] {
        CLASS_OPAQUE      = 2'd0,
        CLASS_MASKED      = 2'd1,
        CLASS_TRANSLUCENT = 2'd2
    } t_class;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
                                                        input logic [TAC_TALLY_W-1:0] t);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, c} + (COUNT_WIDTH + 1)'(t);
        return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    t_fmt  r_fmt;
    logic  r_v1, r_v2, r_v3;
    logic  r_last1, r_last2, r_last3;
    logic [63:0] r_word1, r_word2;
    logic [1:0]  r_cnt1, r_cnt2;
    logic  w_move3, w_load1, w_load2, w_load3;
    t_pipe_en w_en;

    t_flags [TAC_PAL-1:0]      w_pal;
    t_lane_out [TAC_LANES-1:0] w_lane;
    logic [7:0]                w_alpha [TAC_LANES];
    logic [TAC_LANES-1:0]      w_alpha_en;
    logic                      w_solid;
    t_tally                    w_tally;

    logic [COUNT_WIDTH-1:0] r_total, r_clear, r_opaque, r_pass;
    logic [COUNT_WIDTH-1:0] n_total, n_clear, n_opaque, n_pass;
    t_class                 n_class;

    logic                 r_out_valid;
    t_class               r_class;
    logic [TAC_OUT_W-1:0] r_out_total, r_out_clear, r_out_opaque, r_out_pass;

    // a stage moves on unless a last item is blocked at the output register
    assign w_move3 = r_v3 && !(r_last3 && r_out_valid && i_out_stall);
    assign w_load3 = !r_v3 || w_move3;
    assign w_load2 = !r_v2 || w_load3;
    assign w_load1 = !r_v1 || w_load2;
    assign w_en    = '{s1: w_load1, s2: w_load2, s3: w_load3};
    assign o_in_stall = !w_load1;

    tac_palette u_palette (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_endpoints (i_block_word[15:0]),
        .o_pal       (w_pal)
    );

    assign w_solid = (r_word2[15:0] > r_word2[31:16]);

    always_comb begin
        for (int i = 0; i < TAC_LANES; i++) begin
            w_alpha[i] = '0;
        end
        w_alpha[0] = r_word2[31:24];
        w_alpha[1] = r_word2[63:56];
        w_alpha_en    = '0;
        w_alpha_en[0] = (r_cnt2 != 2'd0);
        w_alpha_en[1] = r_cnt2[1];
    end

    for (genvar g = 0; g < TAC_LANES; g++) begin : g_lane
        tac_lane u_lane (
            .i_fmt        (r_fmt),
            .i_nibble     (r_word2[4 * g +: 4]),
            .i_idx2       (r_word2[DXT1_IDX_LSB + 2 * g +: 2]),
            .i_idx3       (r_word2[DXT5_IDX_LSB + 3 * g +: 3]),
            .i_alpha      (w_alpha[g]),
            .i_alpha_en   (w_alpha_en[g]),
            .i_dxt1_solid (w_solid),
            .i_pal        (w_pal),
            .o_lane       (w_lane[g])
        );
    end

    tac_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_load3),
        .i_lanes (w_lane),
        .o_tally (w_tally)
    );

    always_comb begin
        n_total  = sat_add(r_total, w_tally.tot);
        n_clear  = sat_add(r_clear, w_tally.clr);
        n_opaque = sat_add(r_opaque, w_tally.opq);
        n_pass   = sat_add(r_pass, w_tally.pas);
        if (n_total == '0) begin
            n_class = CLASS_MASKED;
        end else if (n_opaque == n_total) begin
            n_class = CLASS_OPAQUE;
        end else if ({n_pass, 2'b00} < {2'b00, n_total}) begin
            n_class = CLASS_TRANSLUCENT;
        end else begin
            n_class = CLASS_MASKED;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_BGRA;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_clear     <= '0;
            r_opaque    <= '0;
            r_pass      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= t_fmt'(i_cfg_data);
            end
            if (w_load1) begin
                r_v1 <= i_in_valid;
            end
            if (w_load2) begin
                r_v2 <= r_v1;
            end
            if (w_load3) begin
                r_v3 <= r_v2;
            end
            if (w_move3) begin
                if (r_last3) begin
                    r_total  <= '0;
                    r_clear  <= '0;
                    r_opaque <= '0;
                    r_pass   <= '0;
                end else begin
                    r_total  <= n_total;
                    r_clear  <= n_clear;
                    r_opaque <= n_opaque;
                    r_pass   <= n_pass;
                end
            end
            if (w_move3 && r_last3) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_word1 <= i_block_word;
            r_cnt1  <= i_pixel_count;
            r_last1 <= i_last_item;
        end
        if (w_load2) begin
            r_word2 <= r_word1;
            r_cnt2  <= r_cnt1;
            r_last2 <= r_last1;
        end
        if (w_load3) begin
            r_last3 <= r_last2;
        end
        if (w_move3 && r_last3) begin
            r_class      <= n_class;
            r_out_total  <= TAC_OUT_W'(n_total);
            r_out_clear  <= TAC_OUT_W'(n_clear);
            r_out_opaque <= TAC_OUT_W'(n_opaque);
            r_out_pass   <= TAC_OUT_W'(n_pass);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_alpha_class    = r_class;
    assign o_total_texels   = r_out_total;
    assign o_clear_texels   = r_out_clear;
    assign o_opaque_texels  = r_out_opaque;
    assign o_passing_texels = r_out_pass;

    `TAC_ASSERT(a_clear_after_last, i_clk, i_rst_n, (w_move3 && r_last3) |=> (r_total == '0), "counters not cleared after last item")
    `TAC_ASSERT(a_last_held, i_clk, i_rst_n, (r_v3 && r_last3 && r_out_valid && i_out_stall) |=> (r_v3 && r_last3), "blocked last item lost")
    `TAC_ASSERT(a_counts_bounded, i_clk, i_rst_n, (r_opaque <= r_total) && (r_pass <= r_total) && (r_clear <= r_total), "category count above total")

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - texture alpha classifier regression
// Directed table of block words for every format, then random textures under
// varying valid/stall idling, a long output hold-off and a long multi-block
// texture. Every result is checked against its table row or an in-bench alpha tally model.
// ----------------------------------------------------------------------------
module tb_top;
    import tac_pkg::*;

    localparam int CLK_PERIOD     = 20;
    // counter width narrower than the output width
    localparam int CNT_W          = 16;
    localparam longint CNT_MAX    = (longint'(1) << CNT_W) - 1;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int GROUP_ITEMS    = 52;
    localparam int PRESSURE_ITEMS = 40;
    localparam int LONG_ITEMS     = 90;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam logic [1:0] CLS_OPAQUE      = 2'd0;
    localparam logic [1:0] CLS_MASKED      = 2'd1;
    localparam logic [1:0] CLS_TRANSLUCENT = 2'd2;

    typedef struct {
        logic [1:0]           cls;
        logic [TAC_OUT_W-1:0] tot;
        logic [TAC_OUT_W-1:0] clr;
        logic [TAC_OUT_W-1:0] opq;
        logic [TAC_OUT_W-1:0] pas;
    } alpha_result_t;

    typedef struct {
        int tot;
        int clr;
        int opq;
        int pas;
    } texel_tally_t;

    typedef struct {
        t_fmt          fmt;
        logic [63:0]   word;
        logic [1:0]    npix;
        logic          last;
        bit            typed;
        alpha_result_t want;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [63:0]          i_block_word = '0;
    logic [1:0]           i_pixel_count = '0;
    logic                 i_last_item = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_alpha_class;
    logic [TAC_OUT_W-1:0] o_total_texels;
    logic [TAC_OUT_W-1:0] o_clear_texels;
    logic [TAC_OUT_W-1:0] o_opaque_texels;
    logic [TAC_OUT_W-1:0] o_passing_texels;

    // model state
    t_fmt           cur_fmt = FMT_BGRA;
    logic [CNT_W-1:0] total_acc = '0;
    logic [CNT_W-1:0] clear_acc = '0;
    logic [CNT_W-1:0] opaque_acc = '0;
    logic [CNT_W-1:0] pass_acc = '0;
    alpha_result_t  pending_results[$];
    stim_row_t      stim_table[$];

    int   items_in = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   stalled_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_out = 1'b0;
    event start_hold;

    texture_alpha_classifier_unit #(
        .COUNT_WIDTH (CNT_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_block_word     (i_block_word),
        .i_pixel_count    (i_pixel_count),
        .i_last_item      (i_last_item),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_alpha_class    (o_alpha_class),
        .o_total_texels   (o_total_texels),
        .o_clear_texels   (o_clear_texels),
        .o_opaque_texels  (o_opaque_texels),
        .o_passing_texels (o_passing_texels)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic texel_tally_t tally_alpha(texel_tally_t t, int a);
        t.tot++;
        if (a <= int'(TAC_CLEAR_MAX)) t.clr++;
        else if (a >= int'(TAC_OPAQUE_MIN)) t.opq++;
        if (a >= int'(TAC_PASS_MIN)) t.pas++;
        return t;
    endfunction

    // per-word texel tally for the given format
    function automatic texel_tally_t tally_word(t_fmt f, logic [63:0] w, logic [1:0] n);
        texel_tally_t t = '{0, 0, 0, 0};
        int pal [8];
        int a0;
        int a1;
        int i;
        case (f)
            FMT_DXT1: begin
                if (w[15:0] > w[31:16]) begin
                    t.tot = 16;
                    t.opq = 16;
                    t.pas = 16;
                end else begin
                    // punch-through: index 3 is transparent black
                    for (i = 0; i < TAC_LANES; i++) begin
                        t.tot++;
                        if (w[32 + 2 * i +: 2] == 2'd3) t.clr++;
                        else begin
                            t.opq++;
                            t.pas++;
                        end
                    end
                end
            end
            FMT_DXT3: begin
                for (i = 0; i < TAC_LANES; i++)
                    t = tally_alpha(t, 17 * int'(w[4 * i +: 4]));
            end
            FMT_DXT5: begin
                a0 = int'(w[7:0]);
                a1 = int'(w[15:8]);
                pal[0] = a0;
                pal[1] = a1;
                if (a0 > a1) begin
                    for (i = 0; i < 6; i++)
                        pal[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
                end else begin
                    for (i = 0; i < 4; i++)
                        pal[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
                    pal[6] = 0;
                    pal[7] = int'(TAC_ALPHA_MAX);
                end
                for (i = 0; i < TAC_LANES; i++)
                    t = tally_alpha(t, pal[w[16 + 3 * i +: 3]]);
            end
            default: begin
                // a pixel count of three counts as two
                if (n >= 2'd1) t = tally_alpha(t, int'(w[31:24]));
                if (n >= 2'd2) t = tally_alpha(t, int'(w[63:56]));
            end
        endcase
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, int n);
        longint s;
        s = longint'(c) + n;
        if (s > CNT_MAX) s = CNT_MAX;
        return s[CNT_W-1:0];
    endfunction

    task automatic absorb_word(input logic [63:0] w, input logic [1:0] n, input logic l,
                               output bit got, output alpha_result_t res);
        texel_tally_t t;
        t = tally_word(cur_fmt, w, n);
        total_acc  = sat_add(total_acc, t.tot);
        clear_acc  = sat_add(clear_acc, t.clr);
        opaque_acc = sat_add(opaque_acc, t.opq);
        pass_acc   = sat_add(pass_acc, t.pas);
        got = l;
        res = '{CLS_MASKED, TAC_OUT_W'(total_acc), TAC_OUT_W'(clear_acc),
                TAC_OUT_W'(opaque_acc), TAC_OUT_W'(pass_acc)};
        if (l) begin
            if (total_acc == 0) res.cls = CLS_MASKED;
            else if (opaque_acc == total_acc) res.cls = CLS_OPAQUE;
            else if (longint'(pass_acc) * 4 < longint'(total_acc)) res.cls = CLS_TRANSLUCENT;
            else res.cls = CLS_MASKED;
            total_acc  = '0;
            clear_acc  = '0;
            opaque_acc = '0;
            pass_acc   = '0;
        end
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return TAC_CLEAR_MAX;
            2:       return TAC_CLEAR_MAX + 8'd1;
            3:       return TAC_PASS_MIN - 8'd1;
            4:       return TAC_PASS_MIN;
            5:       return TAC_OPAQUE_MIN - 8'd1;
            6:       return TAC_OPAQUE_MIN;
            7:       return TAC_ALPHA_MAX;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] random_word(t_fmt f);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case (f)
            FMT_BGRA: begin
                if ($urandom_range(1)) w[31:24] = pick_alpha();
                if ($urandom_range(1)) w[63:56] = pick_alpha();
            end
            FMT_DXT1: begin
                if ($urandom_range(4) == 0) w[31:16] = w[15:0];
            end
            FMT_DXT5: begin
                if ($urandom_range(1)) begin
                    w[7:0]  = pick_alpha();
                    w[15:8] = pick_alpha();
                end
                if ($urandom_range(6) == 0) w[15:8] = w[7:0];
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_row(input t_fmt f, input logic [63:0] w, input logic [1:0] n,
                           input logic l, input bit typed, input logic [1:0] cls,
                           input int tot, input int clr, input int opq, input int pas);
        stim_row_t r;
        r.fmt   = f;
        r.word  = w;
        r.npix  = n;
        r.last  = l;
        r.typed = typed;
        r.want  = '{cls, TAC_OUT_W'(tot), TAC_OUT_W'(clr), TAC_OUT_W'(opq), TAC_OUT_W'(pas)};
        stim_table.push_back(r);
    endtask

    task automatic send_word(input logic [63:0] w, input logic [1:0] n, input logic l,
                             input bit typed, input alpha_result_t want);
        bit got;
        alpha_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_block_word  <= w;
        i_pixel_count <= n;
        i_last_item   <= l;
        do @(posedge i_clk); while (o_in_stall);
        items_in++;
        absorb_word(w, n, l, got, res);
        if (got) begin
            if (typed) pending_results.push_back(want);
            else pending_results.push_back(res);
        end
    endtask

    // format changes only once the pipeline has emptied
    task automatic write_format(input t_fmt f);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = f;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);
    end

    initial forever begin
        @(start_hold);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin
        alpha_result_t want;
        if (i_rst_n && i_in_valid && o_in_stall) stalled_cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: class %0d total %0d clear %0d opaque %0d pass %0d",
                             o_alpha_class, o_total_texels, o_clear_texels,
                             o_opaque_texels, o_passing_texels);
            end else begin
                want = pending_results.pop_front();
                if (o_alpha_class !== want.cls || o_total_texels !== want.tot ||
                    o_clear_texels !== want.clr || o_opaque_texels !== want.opq ||
                    o_passing_texels !== want.pas) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch (exp/act): class %0d/%0d total %0d/%0d",
                                 results_seen, want.cls, o_alpha_class,
                                 want.tot, o_total_texels);
                        $display("    clear %0d/%0d opaque %0d/%0d pass %0d/%0d",
                                 want.clr, o_clear_texels, want.opq, o_opaque_texels,
                                 want.pas, o_passing_texels);
                    end
                end
            end
        end
    end

    initial begin : main_seq
        alpha_result_t none;
        logic [63:0] w;
        int phase;
        int fi;
        int sent;
        int len;
        int r;
        int k;

        none = '{CLS_OPAQUE, '0, '0, '0, '0};
        //       format    word                    npix  last typed class  tot clr opq pas
        add_row(FMT_BGRA, 64'h0,                  2'd0, 1'b1, 1'b1, CLS_MASKED,      0,  0,  0,  0);
        add_row(FMT_BGRA, 64'hFF000000_FF000000,  2'd2, 1'b1, 1'b1, CLS_OPAQUE,      2,  0,  2,  2);
        add_row(FMT_BGRA, 64'h00FFFFFF_00FFFFFF,  2'd3, 1'b1, 1'b1, CLS_TRANSLUCENT, 2,  2,  0,  0);
        add_row(FMT_BGRA, 64'h80FFFFFF_7FFFFFFF,  2'd2, 1'b1, 1'b1, CLS_MASKED,      2,  0,  0,  1);
        add_row(FMT_BGRA, 64'hFA000000_F9000000,  2'd2, 1'b1, 1'b1, CLS_MASKED,      2,  0,  1,  2);
        add_row(FMT_BGRA, 64'h11000000_10000000,  2'd1, 1'b1, 1'b1, CLS_TRANSLUCENT, 1,  1,  0,  0);
        add_row(FMT_BGRA, 64'hFFFFFFFF_FFFFFFFF,  2'd0, 1'b0, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_BGRA, 64'h00123456_FF123456,  2'd1, 1'b0, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_BGRA, 64'h11ABCDEF_80ABCDEF,  2'd2, 1'b1, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_DXT1, 64'hFFFFFFFF_0000FFFF,  2'd0, 1'b1, 1'b1, CLS_OPAQUE,     16,  0, 16, 16);
        add_row(FMT_DXT1, 64'hFFFFFFFF_00000000,  2'd0, 1'b1, 1'b1, CLS_TRANSLUCENT,16, 16,  0,  0);
        add_row(FMT_DXT1, 64'h00000000_FFFF0000,  2'd3, 1'b1, 1'b1, CLS_OPAQUE,     16,  0, 16, 16);
        add_row(FMT_DXT1, 64'h000000FF_00010000,  2'd0, 1'b1, 1'b1, CLS_MASKED,     16,  4, 12, 12);
        add_row(FMT_DXT1, 64'hE4E4E4E4_BEEFBEEF,  2'd0, 1'b0, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_DXT1, 64'h5555AAAA_7BEF7BEE,  2'd0, 1'b1, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_DXT3, 64'hFFFFFFFF_FFFFFFFF,  2'd0, 1'b1, 1'b1, CLS_OPAQUE,     16,  0, 16, 16);
        add_row(FMT_DXT3, 64'h0,                  2'd0, 1'b1, 1'b1, CLS_TRANSLUCENT,16, 16,  0,  0);
        add_row(FMT_DXT3, 64'hFEDCBA98_76543210,  2'd0, 1'b1, 1'b1, CLS_MASKED,     16,  1,  1,  8);
        add_row(FMT_DXT5, 64'h00000000_000000FF,  2'd0, 1'b1, 1'b1, CLS_OPAQUE,     16,  0, 16, 16);
        add_row(FMT_DXT5, 64'hFFFFFFFF_FFFFFF00,  2'd0, 1'b1, 1'b1, CLS_OPAQUE,     16,  0, 16, 16);
        add_row(FMT_DXT5, 64'hFFFFFFFF_FFFF10FF,  2'd0, 1'b1, 1'b1, CLS_TRANSLUCENT,16,  0,  0,  0);
        // every palette index, /5 then /7 then equal endpoints
        add_row(FMT_DXT5, 64'hFAC688FA_C688C840,  2'd0, 1'b0, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_DXT5, 64'hFAC688FA_C68840C8,  2'd0, 1'b0, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);
        add_row(FMT_DXT5, 64'hFAC688FA_C6888080,  2'd0, 1'b1, 1'b0, CLS_OPAQUE,      0,  0,  0,  0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 28;
        recv_idle_pct = 51;
        for (r = 0; r < stim_table.size(); r++) begin
            if (stim_table[r].fmt != cur_fmt) write_format(stim_table[r].fmt);
            send_word(stim_table[r].word, stim_table[r].npix, stim_table[r].last,
                      stim_table[r].typed, stim_table[r].want);
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 28 : 0;
            for (fi = 0; fi < 4; fi++) begin
                write_format(t_fmt'((fi + phase) % 4));
                sent = 0;
                while (sent < GROUP_ITEMS) begin
                    k = $urandom_range(99);
                    if (k < 70) len = $urandom_range(4, 1);
                    else if (k < 95) len = $urandom_range(16, 5);
                    else len = $urandom_range(40, 17);
                    for (k = 0; k < len; k++)
                        send_word(random_word(cur_fmt), 2'($urandom_range(3)),
                                  k == len - 1, 1'b0, none);
                    sent += len;
                end
            end
        end

        // output held off while single-word textures keep coming
        write_format(FMT_BGRA);
        -> start_hold;
        for (k = 0; k < PRESSURE_ITEMS; k++)
            send_word(random_word(FMT_BGRA), 2'($urandom_range(3)), 1'b1, 1'b0, none);

        // one long texture of mostly opaque blocks
        write_format(FMT_DXT1);
        for (k = 0; k < LONG_ITEMS; k++) begin
            w = random_word(FMT_DXT1);
            if ($urandom_range(9) != 0) begin
                w[15] = 1'b1;
                w[31] = 1'b0;
            end
            send_word(w, 2'($urandom_range(3)), k == LONG_ITEMS - 1, 1'b0, none);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        mismatches += pending_results.size();

        $display("covered %0d input transfers and %0d results over all four formats,",
                 items_in, results_seen);
        $display("random idling, %0d input stall cycles and a long multi-block texture",
                 stalled_cycles);
        if (mismatches == 0) begin
            $display("texture_alpha_classifier_unit regression: pass");
        end else begin
            $display("texture_alpha_classifier_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("texture_alpha_classifier_unit regression: fail");
        $finish;
    end

endmodule
